// ----- design/asg_pkg.sv -----
`default_nettype none
package asg_pkg;

    localparam int DELAY_W = 16;
    localparam int TICK_W  = 10;
    localparam int WARM_W  = 5;
    localparam int GRAN_W  = 3;
    localparam int CODE_W  = 2;
    localparam int TGT_W   = TICK_W + GRAN_W;

    localparam logic [CODE_W-1:0] CHG_NONE = 2'd0;
    localparam logic [CODE_W-1:0] CHG_UP   = 2'd1;
    localparam logic [CODE_W-1:0] CHG_DOWN = 2'd2;

    localparam logic [1:0] REG_TICK = 2'd0;
    localparam logic [1:0] REG_WARM = 2'd1;
    localparam logic [1:0] REG_GMAX = 2'd2;

    localparam logic [TICK_W-1:0] TICK_RST = 10'd8;
    localparam logic [WARM_W-1:0] WARM_RST = 5'd10;
    localparam logic [GRAN_W-1:0] GMAX_RST = 3'd4;
    localparam logic [GRAN_W-1:0] GRAN_RST = 3'd1;

    typedef struct packed {
        logic [TICK_W-1:0] tick_period_ms;
        logic [WARM_W-1:0] warmup_samples;
        logic [GRAN_W-1:0] max_granularity;
    } asg_cfg_t;

    typedef struct packed {
        logic               valid;
        logic [DELAY_W-1:0] delay;
    } asg_q_t;

endpackage
`default_nettype wire

// ----- design/asg_queue.sv -----
`default_nettype none
module asg_queue (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [15:0]               s_measured_delay,
    output asg_pkg::asg_q_t                q_head,
    input  wire logic                      q_pop
);
    import asg_pkg::*;

    logic [DELAY_W-1:0] slot_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         fill_reg, fill_next;
    logic               push;
    logic               pop;

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (fill_reg != 2'd0);

    assign q_head = {(fill_reg != 2'd0), slot_reg[rd_ptr_reg]};

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_measured_delay;
        end
    end

endmodule
`default_nettype wire

// ----- design/asg_div.sv -----
`default_nettype none
module asg_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule
`default_nettype wire

// ----- design/asg_back.sv -----
`default_nettype none
module asg_back #(
    parameter int HISTORY_DEPTH = 21
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire asg_pkg::asg_cfg_t cfg,
    input  wire asg_pkg::asg_q_t   q_head,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_granularity_ticks,
    output logic [15:0]            m_average_delay,
    output logic [1:0]             m_change_code
);
    import asg_pkg::*;

    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int IW   = $clog2(HISTORY_DEPTH);
    localparam int SW   = DELAY_W + CW;
    localparam int CMPW = (CW > WARM_W) ? CW : WARM_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [IW-1:0] LAST_C  = IW'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_DECIDE
    } state_t;

    state_t             state_reg, state_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      oldest_reg, oldest_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic [GRAN_W-1:0]  gran_reg, gran_next;
    logic [TGT_W-1:0]   target_reg, target_next;
    logic               m_valid_reg, m_valid_next;
    logic [GRAN_W-1:0]  m_gran_reg, m_gran_next;
    logic [DELAY_W-1:0] m_avg_reg, m_avg_next;
    logic [CODE_W-1:0]  m_code_reg, m_code_next;

    logic [DELAY_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [DELAY_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [CW:0]        fill_addr;

    logic               full;
    logic               div_done;
    logic [SW-1:0]      div_quo;
    logic [DELAY_W-1:0] mean;
    logic [TGT_W-1:0]   half_target;
    logic               active;
    logic               load_out;

    assign m_valid             = m_valid_reg;
    assign m_granularity_ticks = m_gran_reg;
    assign m_average_delay     = m_avg_reg;
    assign m_change_code       = m_code_reg;

    assign full        = (count_reg == DEPTH_C);
    assign fill_addr   = {1'b0, CW'(oldest_reg)} + {1'b0, count_reg};
    assign wr_addr     = full ? oldest_reg
                       : (fill_addr >= (CW+1)'(HISTORY_DEPTH))
                         ? IW'(fill_addr - (CW+1)'(HISTORY_DEPTH))
                         : IW'(fill_addr);
    assign wr_en       = (state_reg == S_UPDATE);
    assign q_pop       = (state_reg == S_IDLE) && q_head.valid;

    assign mean        = div_quo[DELAY_W-1:0];
    assign half_target = target_reg >> 1;
    assign active      = (CMPW'(count_reg) > CMPW'(cfg.warmup_samples));
    assign load_out    = (state_reg == S_DECIDE);

    asg_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_UPDATE),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next   = state_reg;
        delay_next   = delay_reg;
        count_next   = count_reg;
        oldest_next  = oldest_reg;
        sum_next     = sum_reg;
        gran_next    = gran_reg;
        target_next  = target_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_gran_next  = m_gran_reg;
        m_avg_next   = m_avg_reg;
        m_code_next  = m_code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_head.valid) begin
                    delay_next = q_head.delay;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // drop the oldest beat from the sum once the window is full
                sum_next    = sum_reg - (full ? SW'(rd_data_reg) : SW'(0))
                            + SW'(delay_reg);
                count_next  = full ? count_reg : count_reg + CW'(1);
                oldest_next = !full ? oldest_reg
                            : (oldest_reg == LAST_C) ? IW'(0) : oldest_reg + IW'(1);
                target_next = TGT_W'(cfg.tick_period_ms) * TGT_W'(gran_reg);
                state_next  = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!m_valid_reg || m_ready) begin
                    m_code_next = CHG_NONE;
                    if (active && (mean > DELAY_W'(target_reg))) begin
                        if (gran_reg < cfg.max_granularity) begin
                            gran_next   = gran_reg + GRAN_W'(1);
                            m_code_next = CHG_UP;
                        end
                    end else if (active && (mean < DELAY_W'(half_target))) begin
                        if (gran_reg > GRAN_W'(1)) begin
                            gran_next   = gran_reg - GRAN_W'(1);
                            m_code_next = CHG_DOWN;
                        end
                    end
                    m_gran_next  = gran_next;
                    m_avg_next   = mean;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            oldest_reg  <= '0;
            sum_reg     <= '0;
            gran_reg    <= GRAN_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            oldest_reg  <= oldest_next;
            sum_reg     <= sum_next;
            gran_reg    <= gran_next;
            m_valid_reg <= m_valid_next;
        end
        delay_reg  <= delay_next;
        target_reg <= target_next;
        m_gran_reg <= m_gran_next;
        m_avg_reg  <= m_avg_next;
        m_code_reg <= m_code_next;
    end

    // window storage: read the oldest slot every cycle, write on update
    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[oldest_reg];
        if (wr_en) begin
            hist_mem[wr_addr] <= delay_reg;
        end
    end

    a_gran_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        gran_reg != GRAN_W'(0))
        else $error("granularity reached zero");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("window count beyond depth");

    a_up_step: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && !(m_valid_reg && !m_ready) && (m_code_next == CHG_UP)
        |=> gran_reg == $past(gran_reg) + GRAN_W'(1))
        else $error("increase reported without granularity step");

    a_oldest_still: assert property (@(posedge aclk) disable iff (!aresetn)
        !full |=> oldest_reg == $past(oldest_reg))
        else $error("oldest slot moved before window filled");

endmodule
`default_nettype wire

// ----- design/adaptive_sleep_granularity.sv -----
`default_nettype none
// Adaptive sleep granularity controller. Each input beat carries one measured
// sleep delay in ms; the block keeps a sliding window of the last HISTORY_DEPTH
// delays with a running sum, forms the truncated mean and steps the granularity
// up (no higher than max_granularity) when the mean exceeds tick_period_ms *
// granularity and down (no lower than 1) when it falls below half of that,
// once the window holds more than warmup_samples delays. Every input beat
// yields exactly one result beat. An item passes through the back end in
// order: a pop, an update of the window memory and sum, the
// 16 + clog2(HISTORY_DEPTH+1) bit bit-serial divider that forms the mean, a
// step to see the divider finish, and a step to decide and load the output
// register; a result still waiting for the receiver holds the decide step. A
// two-entry queue in front takes beats while the back end works. Registers sit
// on an APB port at 0x0 (tick_period_ms), 0x4 (warmup_samples), 0x8
// (max_granularity); the user must write them only while the block is idle,
// and the block itself does not enforce this.
module adaptive_sleep_granularity #(
    parameter int HISTORY_DEPTH = 21
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_measured_delay,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_granularity_ticks,
    output logic [15:0]      m_average_delay,
    output logic [1:0]       m_change_code
);
    import asg_pkg::*;

    asg_cfg_t cfg_reg, cfg_next;
    asg_q_t   q_head;
    logic     q_pop;
    logic     wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_hit) begin
            unique case (paddr[3:2])
                REG_TICK: cfg_next.tick_period_ms  = pwdata[TICK_W-1:0];
                REG_WARM: cfg_next.warmup_samples  = pwdata[WARM_W-1:0];
                REG_GMAX: cfg_next.max_granularity = pwdata[GRAN_W-1:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_period_ms  <= TICK_RST;
            cfg_reg.warmup_samples  <= WARM_RST;
            cfg_reg.max_granularity <= GMAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TICK: prdata = 32'(cfg_reg.tick_period_ms);
            REG_WARM: prdata = 32'(cfg_reg.warmup_samples);
            REG_GMAX: prdata = 32'(cfg_reg.max_granularity);
            default:  prdata = 32'd0;
        endcase
    end

    asg_queue u_queue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_delay (s_measured_delay),
        .q_head           (q_head),
        .q_pop            (q_pop)
    );

    asg_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .q_head              (q_head),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_granularity_ticks (m_granularity_ticks),
        .m_average_delay     (m_average_delay),
        .m_change_code       (m_change_code)
    );

endmodule
`default_nettype wire

// ----- tb/adaptive_sleep_granularity_test.sv -----
`timescale 1ns / 100ps

module adaptive_sleep_granularity_test;
    import asg_pkg::*;

    localparam int HISTORY_DEPTH  = 21;
    localparam int LATENCY_CYCLES = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_PHASES     = 12;

    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_MOSTLY   = 2;
    localparam int RX_PERIODIC = 3;

    typedef struct {
        logic [GRAN_W-1:0]  gran;
        logic [DELAY_W-1:0] avg;
        logic [CODE_W-1:0]  code;
    } sleep_result_t;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [3:0]         paddr            = '0;
    logic [31:0]        pwdata           = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic [DELAY_W-1:0] s_measured_delay = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [GRAN_W-1:0]  m_granularity_ticks;
    logic [DELAY_W-1:0] m_average_delay;
    logic [CODE_W-1:0]  m_change_code;

    logic [DELAY_W-1:0] pending_delays [$];
    sleep_result_t      expected_results [$];

    // Shadow of the controller state and its registers
    logic [DELAY_W-1:0] window_delays [HISTORY_DEPTH];
    int unsigned        window_count = 0;
    int unsigned        window_head  = 0;
    int unsigned        window_sum   = 0;
    int unsigned        gran_now     = GRAN_RST;
    int unsigned        cfg_tick     = TICK_RST;
    int unsigned        cfg_warm     = WARM_RST;
    int unsigned        cfg_gmax     = GMAX_RST;

    logic in_taken     = 1'b0;
    logic rx_hold      = 1'b0;
    int   mismatches   = 0;
    int   results_seen = 0;
    int   stall_cycles = 0;
    int   burst_left   = 0;
    int   gap_left     = 0;
    int   rx_mode      = RX_OPEN;
    int   rx_mode_left = 0;
    int   rx_tick      = 0;

    adaptive_sleep_granularity #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_measured_delay   (s_measured_delay),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_granularity_ticks(m_granularity_ticks),
        .m_average_delay    (m_average_delay),
        .m_change_code      (m_change_code)
    );

    always #1 aclk = ~aclk;

    function automatic sleep_result_t step_granularity(input logic [DELAY_W-1:0] delay);
        sleep_result_t r;
        int unsigned   mean;
        int unsigned   target;
        r.code = CHG_NONE;
        // full window: retire the oldest delay into the slot of the new one
        if (window_count >= HISTORY_DEPTH) begin
            window_sum = window_sum - window_delays[window_head];
            window_delays[window_head] = delay;
            window_head = (window_head + 1) % HISTORY_DEPTH;
        end else begin
            window_delays[(window_head + window_count) % HISTORY_DEPTH] = delay;
            window_count++;
        end
        window_sum = window_sum + delay;
        mean   = window_sum / window_count;
        target = cfg_tick * gran_now;
        if (window_count > cfg_warm && mean > target) begin
            if (gran_now < cfg_gmax) begin
                gran_now++;
                r.code = CHG_UP;
            end
        end else if (window_count > cfg_warm && mean < target / 2) begin
            if (gran_now > 1) begin
                gran_now--;
                r.code = CHG_DOWN;
            end
        end
        r.gran = gran_now[GRAN_W-1:0];
        r.avg  = mean[DELAY_W-1:0];
        return r;
    endfunction

    task automatic apb_write(input logic [1:0] idx, input int unsigned value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TICK: cfg_tick = value & 32'h3FF;
            REG_WARM: cfg_warm = value & 32'h1F;
            REG_GMAX: cfg_gmax = value & 32'h7;
            default: ;
        endcase
    endtask

    task automatic wait_until_drained();
        while (pending_delays.size() != 0 || expected_results.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (LATENCY_CYCLES) @(negedge aclk);
    endtask

    // Sender: bursts of beats separated by random gaps
    always @(negedge aclk) begin
        logic               nxt_valid;
        logic [DELAY_W-1:0] nxt_delay;
        nxt_valid = s_valid;
        nxt_delay = s_measured_delay;
        if (!s_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_delays.size() != 0) begin
                nxt_valid = 1'b1;
                nxt_delay = pending_delays[0];
                pending_delays.delete(0);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 4) == 0) begin
                        burst_left = $urandom_range(100, 300);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(1, 15);
                    end
                end
            end
        end
        s_valid          <= nxt_valid;
        s_measured_delay <= nxt_delay;
    end

    // Receiver: switch between stall patterns now and then
    always @(negedge aclk) begin
        logic rdy;
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(RX_OPEN, RX_PERIODIC);
            rx_mode_left = $urandom_range(20, 300);
        end else begin
            rx_mode_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     rdy = 1'b1;
            RX_COIN:     rdy = ($urandom_range(0, 1) != 0);
            RX_MOSTLY:   rdy = ($urandom_range(0, 9) != 0);
            RX_PERIODIC: rdy = ((rx_tick % 7) < 4);
            default:     rdy = 1'b1;
        endcase
        m_ready <= rdy && !rx_hold;
    end

    // Long receiver hold-off while the sender keeps offering beats
    initial begin
        for (int h = 0; h < 2; h++) begin
            do @(posedge aclk);
            while (results_seen < 300 + 600 * h || pending_delays.size() < 40);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold = 1'b0;
        end
    end

    always @(posedge aclk) begin
        sleep_result_t want;
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                                        step_granularity(s_measured_delay));
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: gran %0d avg %0d code %0d",
                                 m_granularity_ticks, m_average_delay, m_change_code);
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (m_granularity_ticks !== want.gran || m_average_delay !== want.avg ||
                        m_change_code !== want.code) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected gran %0d avg %0d code %0d, got %0d %0d %0d",
                                     results_seen, want.gran, want.avg, want.code,
                                     m_granularity_ticks, m_average_delay, m_change_code);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int tick;
        int warm;
        int gmax;
        int n_items;
        int run_left;
        int level;
        int span;
        int pick;
        int d;
        foreach (window_delays[i]) window_delays[i] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extremes, alternating bits, then enough beats to wrap the window
        pending_delays = {16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
                          16'h7FFF, 16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0008, 16'h0009, 16'h0010, 16'h0011, 16'h0004, 16'h0003,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            wait_until_drained();
            n_items = 150;
            case (ph)
                1: begin tick = 8;    warm = 10; gmax = 4; end
                2: begin tick = 1;    warm = 0;  gmax = 7; end
                3: begin tick = 1000; warm = 21; gmax = 7; end
                // warmup past the depth: never adjusts
                4: begin tick = 1023; warm = 31; gmax = 7; n_items = 100; end
                // zero tick: target is zero, only rises
                5: begin tick = 0;    warm = 5;  gmax = 7; n_items = 100; end
                6: begin tick = 50;   warm = 3;  gmax = 7; n_items = 100; end
                // granularity left above a lowered maximum
                7: begin tick = 50;   warm = 3;  gmax = 1; end
                8: begin tick = 30;   warm = 0;  gmax = 0; n_items = 100; end
                default: begin
                    tick    = $urandom_range(0, 1023);
                    warm    = $urandom_range(0, 31);
                    gmax    = $urandom_range(0, 7);
                    n_items = 150;
                end
            endcase
            apb_write(REG_TICK, tick);
            apb_write(REG_WARM, warm);
            apb_write(REG_GMAX, gmax);

            // wander between delay levels so the mean crosses the thresholds
            span     = tick * ((gmax == 0) ? 1 : gmax) + 1;
            run_left = 0;
            level    = 0;
            for (int i = 0; i < n_items; i++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(5, 40);
                    level    = int'($urandom_range(0, 2 * span));
                end
                run_left--;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    d = int'($urandom & 32'hFFFF);
                else if (pick < 11)
                    d = pick[0] ? 32'hFFFF : 0;
                else
                    d = level + int'($urandom_range(0, span)) - span / 2;
                if (d < 0)
                    d = 0;
                if (d > 65535)
                    d = 65535;
                pending_delays.insert(pending_delays.size(), d[DELAY_W-1:0]);
            end
        end

        wait_until_drained();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/asg_pkg.sv
design/asg_queue.sv
design/asg_div.sv
design/asg_back.sv
design/adaptive_sleep_granularity.sv
tb/adaptive_sleep_granularity_test.sv
